// ===== hdl/lvs_pkg.sv =====
// ----------------------------------------------------------------------------
// lvs_pkg
// shared types and constants of the line voxel sampler
// ----------------------------------------------------------------------------
package lvs_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_X  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_Y  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_Z  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_X = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_Y = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_Z = 3'd5;

  typedef struct packed {
    logic [5:0] size_x;
    logic [5:0] size_y;
    logic [5:0] size_z;
    logic [4:0] start_x;
    logic [4:0] start_y;
    logic [4:0] start_z;
  } cfg_t;

  typedef struct packed {
    logic [14:0] base;
    logic [5:0]  r;
    logic [4:0]  dx;
    logic [4:0]  dy;
    logic [4:0]  dz;
    logic        nx;
    logic        ny;
    logic        nz;
    logic [5:0]  sx;
    logic [10:0] sxy;
  } job_t;

  function automatic logic [5:0] eff_size(input logic [5:0] s, input logic [5:0] lim);
    logic [5:0] v;
    v = s;
    if (s == 6'd0) v = 6'd1;
    else if (s > lim) v = lim;
    return v;
  endfunction

  function automatic logic [4:0] clamp_coord(input logic [4:0] c, input logic [5:0] s);
    logic [5:0] m;
    m = s - 6'd1;
    return ({1'b0, c} > m) ? m[4:0] : c;
  endfunction

endpackage

// ===== hdl/lvs_if.sv =====
// ----------------------------------------------------------------------------
// lvs channel interfaces
// valid/ready channels for end voxels, addresses and register writes
// ----------------------------------------------------------------------------
interface lvs_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] end_x;
  logic [4:0] end_y;
  logic [4:0] end_z;
  modport source (output valid, end_x, end_y, end_z, input ready);
  modport sink (input valid, end_x, end_y, end_z, output ready);
endinterface

interface lvs_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] voxel_address;
  logic        last;
  modport source (output valid, voxel_address, last, input ready);
  modport sink (input valid, voxel_address, last, output ready);
endinterface

interface lvs_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [5:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/line_voxel_sampler_3d.sv =====
// ----------------------------------------------------------------------------
// line_voxel_sampler_3d
// samples a 3d segment uniformly and emits distinct linear voxel addresses
//
//   channel  dir  payload
//   cfg_ch   in   index, data (register write)
//   in_ch    in   end_x, end_y, end_z
//   out_ch   out  voxel_address, last
//
// front: one request at a time, waits for queue room, length set by the one-step-a-cycle square root
// back: one request at a time, one sample a cycle, stalls while out_ch is held
// a two-entry queue lets the front work on the next request during the back walk
// rst is synchronous; registers reset to 32,32,32,0,0,0
// ----------------------------------------------------------------------------
module line_voxel_sampler_3d import lvs_pkg::*; #(
  parameter int AXIS_SIZE = 32
) (
  input  logic      clk,
  input  logic      rst,
  lvs_cfg_if.sink   cfg_ch,
  lvs_in_if.sink    in_ch,
  lvs_out_if.source out_ch
);

  cfg_t cfg;
  logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  job_t q_push_data, q_pop_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{size_x: 6'd32, size_y: 6'd32, size_z: 6'd32,
               start_x: 5'd0, start_y: 5'd0, start_z: 5'd0};
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SIZE_X:  cfg.size_x  <= cfg_ch.data;
        CFG_SIZE_Y:  cfg.size_y  <= cfg_ch.data;
        CFG_SIZE_Z:  cfg.size_z  <= cfg_ch.data;
        CFG_START_X: cfg.start_x <= cfg_ch.data[4:0];
        CFG_START_Y: cfg.start_y <= cfg_ch.data[4:0];
        CFG_START_Z: cfg.start_z <= cfg_ch.data[4:0];
        default: ;
      endcase
    end
  end

  lvs_front #(.AXIS_SIZE(AXIS_SIZE)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .job_valid (q_push_valid),
    .job_ready (q_push_ready),
    .job       (q_push_data)
  );

  lvs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  lvs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_pop_valid),
    .job_ready (q_pop_ready),
    .job_in    (q_pop_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== hdl/lvs_front.sv =====
// ----------------------------------------------------------------------------
// lvs_front
// accepts end voxels, clamps, forms base address and rounded length
// ----------------------------------------------------------------------------
module lvs_front import lvs_pkg::*; #(
  parameter int AXIS_SIZE = 32
) (
  input  logic       clk,
  input  logic       rst,
  lvs_in_if.sink     in_ch,
  input  cfg_t       cfg,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_PREP = 3'd1;
  localparam logic [2:0] F_BASE = 3'd2;
  localparam logic [2:0] F_SQRT = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;
  localparam logic [5:0] SIZE_LIM = 6'(AXIS_SIZE);

  logic [2:0]  state;
  logic [4:0]  ex, ey, ez;
  logic [4:0]  ax, ay, az;
  logic [11:0] d2;
  logic [5:0]  sx_e, sy_e, sz_e;
  logic [4:0]  bx, by, bz;
  logic [12:0] prod;

  assign in_ch.ready = (state == F_IDLE);
  assign job_valid   = (state == F_PUSH);

  always_comb begin
    sx_e = eff_size(cfg.size_x, SIZE_LIM);
    sy_e = eff_size(cfg.size_y, SIZE_LIM);
    sz_e = eff_size(cfg.size_z, SIZE_LIM);
    bx   = clamp_coord(ex, sx_e);
    by   = clamp_coord(ey, sy_e);
    bz   = clamp_coord(ez, sz_e);
    prod = 13'({7'd0, job.r} + 13'd1) * 13'({7'd0, job.r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_ch.valid) begin
            ex    <= in_ch.end_x;
            ey    <= in_ch.end_y;
            ez    <= in_ch.end_z;
            state <= F_PREP;
          end
        end
        F_PREP: begin
          ax      <= clamp_coord(cfg.start_x, sx_e);
          ay      <= clamp_coord(cfg.start_y, sy_e);
          az      <= clamp_coord(cfg.start_z, sz_e);
          job.dx  <= (clamp_coord(cfg.start_x, sx_e) > bx) ?
                     clamp_coord(cfg.start_x, sx_e) - bx : bx - clamp_coord(cfg.start_x, sx_e);
          job.dy  <= (clamp_coord(cfg.start_y, sy_e) > by) ?
                     clamp_coord(cfg.start_y, sy_e) - by : by - clamp_coord(cfg.start_y, sy_e);
          job.dz  <= (clamp_coord(cfg.start_z, sz_e) > bz) ?
                     clamp_coord(cfg.start_z, sz_e) - bz : bz - clamp_coord(cfg.start_z, sz_e);
          job.nx  <= clamp_coord(cfg.start_x, sx_e) > bx;
          job.ny  <= clamp_coord(cfg.start_y, sy_e) > by;
          job.nz  <= clamp_coord(cfg.start_z, sz_e) > bz;
          job.sx  <= sx_e;
          job.sxy <= 11'(sx_e * sy_e);
          state   <= F_BASE;
        end
        F_BASE: begin
          job.base <= 15'({10'd0, ax} + 15'(ay * job.sx) + 15'(az * job.sxy));
          d2       <= 12'(job.dx * job.dx) + 12'(job.dy * job.dy) + 12'(job.dz * job.dz);
          job.r    <= 6'd0;
          state    <= F_SQRT;
        end
        F_SQRT: begin
          if (d2 == 12'd0) begin
            state <= F_IDLE;
          end else if (prod < {1'b0, d2}) begin
            job.r <= job.r + 6'd1;
          end else begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lvs_queue.sv =====
// ----------------------------------------------------------------------------
// lvs_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module lvs_queue import lvs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  job_t       mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_data;
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== hdl/lvs_back.sv =====
// ----------------------------------------------------------------------------
// lvs_back
// steps samples incrementally and emits distinct addresses
// ----------------------------------------------------------------------------
module lvs_back import lvs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  output logic    job_ready,
  input  job_t    job_in,
  lvs_out_if.source out_ch
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_RUN  = 1'b1;

  logic        state;
  job_t        job;
  logic [5:0]  i;
  logic [6:0]  rem_x, rem_y, rem_z;
  logic [6:0]  rem_x_next, rem_y_next, rem_z_next;
  logic [14:0] step_x, step_y, step_z;
  logic [14:0] addr, addr_next;
  logic [6:0]  tr;
  logic        can_load;

  assign job_ready = (state == B_IDLE);
  assign can_load  = !out_ch.valid || out_ch.ready;
  assign tr        = {job.r, 1'b0};

  function automatic void axis_step(input logic [6:0] rem, input logic [4:0] d,
                                    input logic neg, input logic [6:0] t2r,
                                    input logic [14:0] stride,
                                    output logic [6:0] rem_o, output logic [14:0] dlt);
    logic [7:0] t;
    logic [7:0] d2;
    d2    = {2'b0, d, 1'b0};
    dlt   = 15'd0;
    rem_o = rem;
    if (!neg) begin
      t = {1'b0, rem} + d2;
      if (t >= {1'b0, t2r}) begin
        rem_o = 7'(t - {1'b0, t2r});
        dlt   = stride;
      end else begin
        rem_o = t[6:0];
      end
    end else begin
      if ({1'b0, rem} >= d2) begin
        rem_o = 7'({1'b0, rem} - d2);
      end else begin
        rem_o = 7'({1'b0, rem} + {1'b0, t2r} - d2);
        dlt   = 15'(-stride);
      end
    end
  endfunction

  always_comb begin
    axis_step(rem_x, job.dx, job.nx, tr, 15'd1, rem_x_next, step_x);
    axis_step(rem_y, job.dy, job.ny, tr, {9'd0, job.sx}, rem_y_next, step_y);
    axis_step(rem_z, job.dz, job.nz, tr, {4'd0, job.sxy}, rem_z_next, step_z);
    addr_next = addr + step_x + step_y + step_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (out_ch.ready) out_ch.valid <= 1'b0;
          if (job_valid) begin
            job                  <= job_in;
            rem_x                <= {1'b0, job_in.r};
            rem_y                <= {1'b0, job_in.r};
            rem_z                <= {1'b0, job_in.r};
            addr                 <= job_in.base;
            out_ch.voxel_address <= out_ch.voxel_address;
            i                    <= 6'd0;
            state                <= B_RUN;
          end
        end
        B_RUN: begin
          if (can_load) begin
            if (i == job.r) begin
              out_ch.valid         <= 1'b1;
              out_ch.voxel_address <= addr;
              out_ch.last          <= 1'b1;
              state                <= B_IDLE;
            end else begin
              out_ch.valid <= (addr_next != addr);
              if (addr_next != addr) begin
                out_ch.voxel_address <= addr;
                out_ch.last          <= 1'b0;
              end
              addr  <= addr_next;
              rem_x <= rem_x_next;
              rem_y <= rem_y_next;
              rem_z <= rem_z_next;
              i     <= i + 6'd1;
            end
          end
        end
        default: begin
          out_ch.valid <= 1'b0;
          state        <= B_IDLE;
        end
      endcase
    end
  end

endmodule
